// File: hw/rtl/kcst_pkg.sv
package kcst_pkg;

  // Default table geometry.
  localparam int unsigned SignalingEntriesDef = 8;
  localparam int unsigned ChannelEntriesDef   = 16;
  localparam int unsigned EngineWordWidthDef  = 32;

  // Field widths of the words on the channels.
  localparam int unsigned HandleW    = 12;
  localparam int unsigned ChanIdW    = 16;
  localparam int unsigned TransportW = 2;
  localparam int unsigned IdentW     = 8;
  localparam int unsigned ModeW      = 3;
  localparam int unsigned InWordW    = 32;
  localparam int unsigned SigUsedW   = 4;
  localparam int unsigned ChanUsedW  = 5;

  // Status codes.
  localparam logic STATUS_OK        = 1'b0;
  localparam logic STATUS_EXHAUSTED = 1'b1;

  typedef enum logic [1:0] {
    ACT_SIG_UPSERT  = 2'd0,
    ACT_CHAN_UPSERT = 2'd1,
    ACT_CHAN_REMOVE = 2'd2,
    ACT_RESERVED    = 2'd3
  } kcst_action_e;

  // Input word.
  typedef struct packed {
    kcst_action_e          action;
    logic [HandleW-1:0]    link_handle;
    logic [ChanIdW-1:0]    local_channel;
    logic [ChanIdW-1:0]    remote_channel;
    logic [TransportW-1:0] transport_kind;
    logic [IdentW-1:0]     next_ident;
    logic [ModeW-1:0]      channel_mode;
    logic                  recombining;
    logic                  loss_allowed;
    logic [InWordW-1:0]    rx_state_word;
    logic [InWordW-1:0]    tx_state_word;
  } kcst_in_t;

  // Result word.
  typedef struct packed {
    logic                 status_code;
    logic                 hit_existing;
    logic [SigUsedW-1:0]  signaling_used;
    logic [ChanUsedW-1:0] channels_used;
    logic                 incomplete;
  } kcst_out_t;

  // Stored entry layouts.
  typedef struct packed {
    logic [HandleW-1:0]    link_handle;
    logic [TransportW-1:0] transport_kind;
    logic [IdentW-1:0]     next_ident;
  } kcst_sig_entry_t;

  typedef struct packed {
    logic [HandleW-1:0] link_handle;
    logic [ChanIdW-1:0] local_channel;
  } kcst_chan_key_t;

  typedef struct packed {
    logic [ChanIdW-1:0]    remote_channel;
    logic [TransportW-1:0] transport_kind;
    logic [ModeW-1:0]      channel_mode;
    logic                  recombining;
    logic                  loss_allowed;
  } kcst_chan_set_t;

endpackage

// File: hw/rtl/kcst_if.sv
// Input channel: one table action per word.
interface kcst_in_if import kcst_pkg::*; ();
  logic     valid;
  logic     ready;
  kcst_in_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// Output channel: one result per action.
interface kcst_out_if import kcst_pkg::*; ();
  logic      valid;
  logic      ready;
  kcst_out_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: hw/rtl/keyed_channel_state_table_unit.sv
// Keyed channel state table. Two associative tables live in single-port synchronous
// memories: signalling state keyed by link handle, and channel state keyed by link handle
// and local channel id. Each input word is an upsert of either table or a removal from the
// channel table, and gives exactly one result word with the status, whether an existing
// entry matched, the occupancy of both tables and a sticky flag that reports any insert
// refused for want of space. Entries carry valid bits held in flip-flops, which reset
// clears, so no clearing pass is needed and entry order is not kept. One word is handled
// at a time: the key memory is read one entry per cycle, and the scan runs through the
// entries of the table the word addresses until one matches or the last has been compared;
// the unused action code skips the scan. A new word is taken while the previous result
// still waits at the output.
module keyed_channel_state_table_unit import kcst_pkg::*; #(
  parameter int unsigned SIGNALING_ENTRIES = SignalingEntriesDef,
  parameter int unsigned CHANNEL_ENTRIES   = ChannelEntriesDef,
  parameter int unsigned ENGINE_WORD_WIDTH = EngineWordWidthDef
) (
  input logic         clk_i,
  input logic         rst_ni,
  kcst_in_if.sink     in_i,
  kcst_out_if.source  out_o
);

  localparam int unsigned SigIdxW  = (SIGNALING_ENTRIES > 1) ? $clog2(SIGNALING_ENTRIES) : 1;
  localparam int unsigned ChanIdxW = (CHANNEL_ENTRIES > 1) ? $clog2(CHANNEL_ENTRIES) : 1;
  localparam int unsigned ScanW    = (SigIdxW > ChanIdxW) ? SigIdxW : ChanIdxW;
  localparam int unsigned SigCntW  = $clog2(SIGNALING_ENTRIES + 1);
  localparam int unsigned ChanCntW = $clog2(CHANNEL_ENTRIES + 1);
  localparam logic [ScanW-1:0] SigLast  = ScanW'(SIGNALING_ENTRIES - 1);
  localparam logic [ScanW-1:0] ChanLast = ScanW'(CHANNEL_ENTRIES - 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } state_e;

  // Table memories.
  kcst_sig_entry_t              sig_mem      [SIGNALING_ENTRIES];
  kcst_chan_key_t               chan_key_mem [CHANNEL_ENTRIES];
  kcst_chan_set_t               chan_set_mem [CHANNEL_ENTRIES];
  logic [ENGINE_WORD_WIDTH-1:0] chan_rx_mem  [CHANNEL_ENTRIES];
  logic [ENGINE_WORD_WIDTH-1:0] chan_tx_mem  [CHANNEL_ENTRIES];

  state_e                       state_q;
  kcst_in_t                     item_q;
  logic [ScanW-1:0]             scan_q;
  logic [ScanW-1:0]             cmp_idx_q;
  logic                         cmp_live_q;
  logic                         match_q;
  logic                         free_found_q;
  logic [ScanW-1:0]             slot_q;
  logic [SIGNALING_ENTRIES-1:0] sig_valid_q;
  logic [CHANNEL_ENTRIES-1:0]   chan_valid_q;
  logic [SigCntW-1:0]           sig_cnt_q, sig_cnt_d;
  logic [ChanCntW-1:0]          chan_cnt_q, chan_cnt_d;
  logic                         incomplete_q, incomplete_d;
  logic                         out_valid_q;
  kcst_out_t                    out_data_q, out_data_d;
  kcst_sig_entry_t              sig_rdata_q;
  kcst_chan_key_t               chan_key_rdata_q;

  logic             is_sig;
  logic [ScanW-1:0] scan_last;
  logic             cmp_valid;
  logic             cmp_match;
  logic             out_free;
  logic             commit;
  logic             upsert;
  logic             do_write;
  logic             exhausted;
  logic             remove_hit;
  logic             sig_insert;
  logic             chan_insert;
  kcst_chan_key_t   item_key;

  assign in_i.ready  = (state_q == ST_IDLE);
  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_data_q;

  // Compare the entry read in the previous cycle against the key of the held word.
  always_comb begin
    is_sig    = (item_q.action == ACT_SIG_UPSERT);
    scan_last = is_sig ? SigLast : ChanLast;
    item_key  = '{link_handle: item_q.link_handle, local_channel: item_q.local_channel};
    cmp_valid = is_sig ? sig_valid_q[cmp_idx_q[SigIdxW-1:0]]
                       : chan_valid_q[cmp_idx_q[ChanIdxW-1:0]];
    cmp_match = cmp_valid && (is_sig ? (sig_rdata_q.link_handle == item_q.link_handle)
                                     : (chan_key_rdata_q == item_key));
  end

  // Decide the outcome once the scan is over and the output register can take a word.
  always_comb begin
    out_free     = !out_valid_q || out_o.ready;
    commit       = (state_q == ST_DONE) && out_free;
    upsert       = (item_q.action == ACT_SIG_UPSERT) || (item_q.action == ACT_CHAN_UPSERT);
    do_write     = commit && upsert && (match_q || free_found_q);
    exhausted    = upsert && !match_q && !free_found_q;
    remove_hit   = (item_q.action == ACT_CHAN_REMOVE) && match_q;
    sig_insert   = do_write && is_sig && !match_q;
    chan_insert  = do_write && !is_sig && !match_q;
    sig_cnt_d    = sig_cnt_q + SigCntW'(sig_insert);
    chan_cnt_d   = chan_cnt_q + ChanCntW'(chan_insert) - ChanCntW'(commit && remove_hit);
    incomplete_d = incomplete_q | (commit && exhausted);
    out_data_d.status_code    = exhausted ? STATUS_EXHAUSTED : STATUS_OK;
    out_data_d.hit_existing   = match_q;
    out_data_d.signaling_used = SigUsedW'(sig_cnt_d);
    out_data_d.channels_used  = ChanUsedW'(chan_cnt_d);
    out_data_d.incomplete     = incomplete_d;
  end

  // Sequencer, valid bits, counts and the sticky flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      scan_q       <= '0;
      cmp_idx_q    <= '0;
      cmp_live_q   <= 1'b0;
      match_q      <= 1'b0;
      free_found_q <= 1'b0;
      sig_valid_q  <= '0;
      chan_valid_q <= '0;
      sig_cnt_q    <= '0;
      chan_cnt_q   <= '0;
      incomplete_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (in_i.valid) begin
            scan_q       <= '0;
            cmp_live_q   <= 1'b0;
            match_q      <= 1'b0;
            free_found_q <= 1'b0;
            state_q      <= (in_i.data.action == ACT_RESERVED) ? ST_DONE : ST_SCAN;
          end
        end
        ST_SCAN: begin
          cmp_live_q <= 1'b1;
          cmp_idx_q  <= scan_q;
          if (scan_q != scan_last) begin
            scan_q <= scan_q + 1'b1;
          end
          if (cmp_live_q) begin
            if (cmp_match) begin
              match_q <= 1'b1;
              state_q <= ST_DONE;
            end else begin
              if (!cmp_valid) begin
                free_found_q <= 1'b1;
              end
              if (cmp_idx_q == scan_last) begin
                state_q <= ST_DONE;
              end
            end
          end
        end
        ST_DONE: begin
          if (out_free) begin
            state_q <= ST_IDLE;
            if (do_write && is_sig) begin
              sig_valid_q[slot_q[SigIdxW-1:0]] <= 1'b1;
            end
            if (do_write && !is_sig) begin
              chan_valid_q[slot_q[ChanIdxW-1:0]] <= 1'b1;
            end
            if (remove_hit) begin
              chan_valid_q[slot_q[ChanIdxW-1:0]] <= 1'b0;
            end
            sig_cnt_q    <= sig_cnt_d;
            chan_cnt_q   <= chan_cnt_d;
            incomplete_q <= incomplete_d;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase

      // Output register: filled on commit, emptied when the sink takes the word.
      if (commit) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Held word, chosen slot and the result word.
  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      item_q <= in_i.data;
    end
    // A match wins; otherwise the first free slot seen is kept.
    if (state_q == ST_SCAN && cmp_live_q) begin
      if (cmp_match || (!cmp_valid && !free_found_q)) begin
        slot_q <= cmp_idx_q;
      end
    end
    if (commit) begin
      out_data_q <= out_data_d;
    end
  end

  // Key memory reads, one entry per cycle at the scan address.
  always_ff @(posedge clk_i) begin
    sig_rdata_q      <= sig_mem[scan_q[SigIdxW-1:0]];
    chan_key_rdata_q <= chan_key_mem[scan_q[ChanIdxW-1:0]];
  end

  // Write-back of an upserted entry.
  always_ff @(posedge clk_i) begin
    if (do_write && is_sig) begin
      sig_mem[slot_q[SigIdxW-1:0]] <= '{link_handle:    item_q.link_handle,
                                        transport_kind: item_q.transport_kind,
                                        next_ident:     item_q.next_ident};
    end
    if (do_write && !is_sig) begin
      chan_key_mem[slot_q[ChanIdxW-1:0]] <= item_key;
      chan_set_mem[slot_q[ChanIdxW-1:0]] <= '{remote_channel: item_q.remote_channel,
                                             transport_kind: item_q.transport_kind,
                                             channel_mode:   item_q.channel_mode,
                                             recombining:    item_q.recombining,
                                             loss_allowed:   item_q.loss_allowed};
      chan_rx_mem[slot_q[ChanIdxW-1:0]]  <= ENGINE_WORD_WIDTH'(item_q.rx_state_word);
      chan_tx_mem[slot_q[ChanIdxW-1:0]]  <= ENGINE_WORD_WIDTH'(item_q.tx_state_word);
    end
  end

endmodule

// File: hw/rtl/kcst_checker.sv
module kcst_checker import kcst_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_ready_i,
  input logic      out_valid_i,
  input logic      out_ready_i,
  input kcst_out_t out_data_i
);

  logic [2:0] pending_q;
  logic       seen_incomplete_q;

  // Words accepted but not yet delivered, and whether the sticky flag was ever reported.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q         <= '0;
      seen_incomplete_q <= 1'b0;
    end else begin
      pending_q <= pending_q + 3'(in_valid_i && in_ready_i) - 3'(out_valid_i && out_ready_i);
      if (out_valid_i && out_ready_i && out_data_i.incomplete) begin
        seen_incomplete_q <= 1'b1;
      end
    end
  end

  // A stalled result word holds.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_data_i))
    else $error("result word changed while stalled");

  // No result without a word accepted for it, and no more than two words in hand.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!out_valid_i || pending_q != 3'd0) && pending_q <= 3'd2)
    else $error("results and accepted words out of step");

  // A refused insert reports no hit and raises the sticky flag.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_data_i.status_code == STATUS_EXHAUSTED
      |-> !out_data_i.hit_existing && out_data_i.incomplete)
    else $error("exhausted result inconsistent");

  // Once reported, the incomplete flag stays set.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && seen_incomplete_q |-> out_data_i.incomplete)
    else $error("incomplete flag cleared");

endmodule

bind keyed_channel_state_table_unit kcst_checker u_kcst_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_data_i  (out_o.data)
);

// File: tb/keyed_channel_state_table_unit_test.sv
`timescale 1ns / 100ps

module keyed_channel_state_table_unit_test;
  import kcst_pkg::*;

  localparam int unsigned CycleLimit    = 500000;
  localparam int unsigned TailCycles    = 24;
  localparam int unsigned HoldOffCycles = 200;
  localparam int unsigned HoldOffAt     = 400;
  localparam int unsigned IdlePercent   = 13;
  localparam int unsigned PhaseCount    = 8;
  localparam int unsigned PhaseWords    = 200;
  localparam int unsigned MaxHandles    = 24;
  localparam int unsigned MaxChanIds    = 8;

  // A word waiting to be offered; some must wait until the block has gone quiet.
  typedef struct {
    kcst_in_t word;
    bit       wait_quiet;
  } queued_word_t;

  logic clk_i;
  logic rst_ni;

  kcst_in_if  in_ch ();
  kcst_out_if out_ch ();

  keyed_channel_state_table_unit DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  queued_word_t pending_words[$];
  kcst_out_t    expected_results[$];

  int unsigned mismatch_count = 0;
  int unsigned results_checked = 0;
  int unsigned words_accepted = 0;
  int unsigned cycle_count = 0;
  int unsigned hold_left = 0;
  bit          hold_done = 1'b0;
  bit          word_taken = 1'b0;

  // Shadow copy of both tables. Only the keys can show in a result, so the
  // stored channel payloads are not mirrored.
  bit              sig_live [SignalingEntriesDef];
  kcst_sig_entry_t sig_table [SignalingEntriesDef];
  bit              chan_live [ChannelEntriesDef];
  kcst_chan_key_t  chan_keys [ChannelEntriesDef];
  bit              table_incomplete = 1'b0;

  logic [HandleW-1:0] handle_pool [MaxHandles];
  logic [ChanIdW-1:0] chan_id_pool [MaxChanIds];

  // Works out the result of one table action and updates the shadow tables.
  function automatic kcst_out_t predict_table_update(kcst_in_t w);
    kcst_out_t      r;
    kcst_chan_key_t key;
    int             slot;
    int unsigned    sig_count;
    int unsigned    chan_count;
    r = '0;
    r.status_code = STATUS_OK;
    key = {w.link_handle, w.local_channel};
    slot = -1;
    sig_count = 0;
    chan_count = 0;
    case (w.action)
      ACT_SIG_UPSERT: begin
        for (int i = 0; i < SignalingEntriesDef; i++)
          if (slot < 0 && sig_live[i] && sig_table[i].link_handle == w.link_handle) slot = i;
        if (slot >= 0) r.hit_existing = 1'b1;
        else
          for (int i = 0; i < SignalingEntriesDef; i++)
            if (slot < 0 && !sig_live[i]) slot = i;
        if (slot >= 0) begin
          sig_live[slot] = 1'b1;
          sig_table[slot] = {w.link_handle, w.transport_kind, w.next_ident};
        end else begin
          r.status_code = STATUS_EXHAUSTED;
          table_incomplete = 1'b1;
        end
      end
      ACT_CHAN_UPSERT: begin
        for (int i = 0; i < ChannelEntriesDef; i++)
          if (slot < 0 && chan_live[i] && chan_keys[i] == key) slot = i;
        if (slot >= 0) r.hit_existing = 1'b1;
        else
          for (int i = 0; i < ChannelEntriesDef; i++)
            if (slot < 0 && !chan_live[i]) slot = i;
        if (slot >= 0) begin
          chan_live[slot] = 1'b1;
          chan_keys[slot] = key;
        end else begin
          r.status_code = STATUS_EXHAUSTED;
          table_incomplete = 1'b1;
        end
      end
      ACT_CHAN_REMOVE: begin
        for (int i = 0; i < ChannelEntriesDef; i++)
          if (slot < 0 && chan_live[i] && chan_keys[i] == key) slot = i;
        if (slot >= 0) begin
          chan_live[slot] = 1'b0;
          r.hit_existing = 1'b1;
        end
      end
      default: ;
    endcase
    for (int i = 0; i < SignalingEntriesDef; i++) sig_count += sig_live[i];
    for (int i = 0; i < ChannelEntriesDef; i++) chan_count += chan_live[i];
    r.signaling_used = sig_count[SigUsedW-1:0];
    r.channels_used = chan_count[ChanUsedW-1:0];
    r.incomplete = table_incomplete;
    return r;
  endfunction

  // Directed word with the payload all zeros or all ones.
  function automatic kcst_in_t make_word(kcst_action_e act, logic [HandleW-1:0] handle,
                                         logic [ChanIdW-1:0] chan_id, bit ones);
    kcst_in_t w;
    w = ones ? '1 : '0;
    w.action = act;
    w.link_handle = handle;
    w.local_channel = chan_id;
    return w;
  endfunction

  // Random word: keys mostly from the current pools so that entries get hit,
  // sometimes fully random; payload always random.
  function automatic kcst_in_t random_word(int unsigned handles, int unsigned chan_ids,
                                           int unsigned insert_pct);
    kcst_in_t     w;
    logic [127:0] noise;
    int unsigned  roll;
    noise = {$urandom, $urandom, $urandom, $urandom};
    w = noise[$bits(kcst_in_t)-1:0];
    roll = $urandom_range(99);
    if (roll < 4) w.action = ACT_RESERVED;
    else if (roll < 34) w.action = ACT_SIG_UPSERT;
    else if (roll < 34 + insert_pct) w.action = ACT_CHAN_UPSERT;
    else w.action = ACT_CHAN_REMOVE;
    if ($urandom_range(99) >= 8) begin
      w.link_handle = handle_pool[$urandom_range(handles - 1)];
      w.local_channel = chan_id_pool[$urandom_range(chan_ids - 1)];
    end
    return w;
  endfunction

  task automatic queue_word(kcst_in_t w, bit wait_quiet);
    queued_word_t q;
    q.word = w;
    q.wait_quiet = wait_quiet;
    pending_words.insert(pending_words.size(), q);
  endtask

  task automatic report_mismatch(string msg);
    $display("result %0d: %s", results_checked, msg);
    mismatch_count++;
  endtask

  // Clock.
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Cycle counter and run limit.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("== FAIL ==");
      $finish;
    end
  end

  // Input side: note each accepted word and predict its result.
  always @(posedge clk_i) begin
    if (rst_ni && in_ch.valid && in_ch.ready) begin
      expected_results.insert(expected_results.size(), predict_table_update(in_ch.data));
      words_accepted++;
      word_taken = 1'b1;
    end
  end

  // Sender: offers the next pending word at the falling edge, idling at random
  // except over a stretch in the middle of the run.
  always @(negedge clk_i) begin
    if (rst_ni && (!in_ch.valid || word_taken)) begin
      word_taken = 1'b0;
      if (pending_words.size() != 0 &&
          (!pending_words[0].wait_quiet || expected_results.size() == 0) &&
          ((words_accepted >= 600 && words_accepted < 850) ||
           $urandom_range(99) >= IdlePercent)) begin
        in_ch.valid <= 1'b1;
        in_ch.data <= pending_words[0].word;
        pending_words.pop_front();
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls, one long hold-off, and a stretch without stalls.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!hold_done && results_checked >= HoldOffAt) begin
        hold_done = 1'b1;
        hold_left = HoldOffCycles;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= (results_checked >= 900 && results_checked < 1150) ||
                        ($urandom_range(99) >= IdlePercent);
      end
    end
  end

  // Output side: compare each result word with the oldest prediction.
  always @(posedge clk_i) begin
    kcst_out_t want;
    kcst_out_t got;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      got = out_ch.data;
      if (expected_results.size() == 0) begin
        report_mismatch("result word with no prediction waiting");
      end else begin
        want = expected_results.pop_front();
        if (got.status_code !== want.status_code)
          report_mismatch($sformatf("status_code %0b, expected %0b",
                                    got.status_code, want.status_code));
        if (got.hit_existing !== want.hit_existing)
          report_mismatch($sformatf("hit_existing %0b, expected %0b",
                                    got.hit_existing, want.hit_existing));
        if (got.signaling_used !== want.signaling_used)
          report_mismatch($sformatf("signaling_used %0d, expected %0d",
                                    got.signaling_used, want.signaling_used));
        if (got.channels_used !== want.channels_used)
          report_mismatch($sformatf("channels_used %0d, expected %0d",
                                    got.channels_used, want.channels_used));
        if (got.incomplete !== want.incomplete)
          report_mismatch($sformatf("incomplete %0b, expected %0b",
                                    got.incomplete, want.incomplete));
      end
      results_checked++;
    end
  end

  // Stimulus, reset and end of run.
  initial begin
    int unsigned handles;
    int unsigned chan_ids;
    int unsigned insert_pct;
    rst_ni = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    out_ch.ready = 1'b0;

    // Directed part: empty tables, both extremes of the keys, a full
    // signalling table, removal hit and miss, and the unused action code.
    queue_word(make_word(ACT_RESERVED, '0, '0, 1'b0), 1'b0);
    queue_word(make_word(ACT_CHAN_REMOVE, '0, '0, 1'b0), 1'b0);
    queue_word(make_word(ACT_SIG_UPSERT, '0, '0, 1'b0), 1'b0);
    queue_word(make_word(ACT_SIG_UPSERT, '1, '1, 1'b1), 1'b0);
    queue_word(make_word(ACT_SIG_UPSERT, '1, '0, 1'b0), 1'b0);
    for (int i = 1; i <= 6; i++)
      queue_word(make_word(ACT_SIG_UPSERT, HandleW'(i), '0, i[0]), 1'b0);
    queue_word(make_word(ACT_SIG_UPSERT, HandleW'(7), '1, 1'b1), 1'b0);
    queue_word(make_word(ACT_SIG_UPSERT, HandleW'(1), '0, 1'b1), 1'b0);
    queue_word(make_word(ACT_CHAN_UPSERT, '0, '0, 1'b0), 1'b0);
    queue_word(make_word(ACT_CHAN_UPSERT, '1, '1, 1'b1), 1'b0);
    queue_word(make_word(ACT_CHAN_UPSERT, '1, '1, 1'b0), 1'b0);
    queue_word(make_word(ACT_CHAN_UPSERT, '1, '0, 1'b1), 1'b0);
    queue_word(make_word(ACT_CHAN_REMOVE, '1, '1, 1'b0), 1'b0);
    queue_word(make_word(ACT_CHAN_REMOVE, '1, '1, 1'b1), 1'b0);
    queue_word(make_word(ACT_CHAN_UPSERT, '1, '1, 1'b1), 1'b0);
    queue_word(make_word(ACT_RESERVED, '1, '1, 1'b1), 1'b0);

    // Random phases, each with its own key pools and mix of inserts and
    // removals, so that the tables swing between nearly empty and full.
    for (int p = 0; p < PhaseCount; p++) begin
      case (p % 4)
        0: begin handles = 3;  chan_ids = 1; end
        1: begin handles = 8;  chan_ids = 2; end
        2: begin handles = 12; chan_ids = 4; end
        default: begin handles = 24; chan_ids = 8; end
      endcase
      insert_pct = (p % 2 == 0) ? 40 : 25;
      for (int i = 0; i < MaxHandles; i++)
        handle_pool[i] = (i == 0) ? '0 : (i == 1) ? '1 : HandleW'($urandom);
      for (int i = 0; i < MaxChanIds; i++)
        chan_id_pool[i] = (i == 0) ? '0 : (i == 1) ? '1 : ChanIdW'($urandom);
      for (int i = 0; i < PhaseWords; i++)
        queue_word(random_word(handles, chan_ids, insert_pct), i == 0);
    end

    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (pending_words.size() != 0 || in_ch.valid || expected_results.size() != 0)
      @(posedge clk_i);
    repeat (TailCycles) @(posedge clk_i);

    if (mismatch_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
